/* sv/eul_pkg.sv */
// shared constants for the euler pose to transform pipeline
`default_nettype none
package eul_pkg;

  // number of series terms evaluated per sine and per cosine
  localparam int N_TERMS = 8;

  // sine/cosine unit latency: fold, square, three stages per term, sign fix
  localparam int SC_LAT = 3 * N_TERMS + 3;

  // matrix product stages after the sine/cosine unit
  localparam int MAT_LAT = 4;

  // Q30 constants, wide enough to compare against a folded angle
  localparam logic signed [34:0] Q30_PI  = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HPI = 35'sd1686629713;
  localparam logic [31:0]        Q30_ONE = 32'd1073741824;

endpackage
`default_nettype wire

/* sv/eul_sincos.sv */
// pipelined series sine and cosine of one q3.x angle, q30 results
`default_nettype none
module eul_sincos #(
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [ANGLE_WIDTH-1:0] ang,
  output logic signed [33:0]                 sin_o,
  output logic signed [33:0]                 cos_o
);
  import eul_pkg::*;

  localparam int SHIFT = 33 - ANGLE_WIDTH;
  localparam int FLAG_LAT = 3 * N_TERMS;

  // fold stage
  logic signed [34:0] z;
  logic signed [34:0] zf;
  logic               flip;
  logic [30:0]        x_r;
  logic               neg_r, flip_r;

  always_comb begin
    z = 35'(ang) <<< SHIFT;
    zf = z;
    flip = 1'b0;
    if (z > Q30_HPI) begin
      zf = z - Q30_PI;
      flip = 1'b1;
    end else if (z < -Q30_HPI) begin
      zf = z + Q30_PI;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= zf[34] ? 31'(-zf) : 31'(zf);
      neg_r <= zf[34];
      flip_r <= flip;
    end
  end

  // square stage
  logic [61:0] sq_r;
  logic [30:0] xs_r;
  logic [1:0]  flg_r [FLAG_LAT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= 62'(x_r) * 62'(x_r);
      xs_r <= x_r;
      flg_r[0] <= {flip_r, neg_r};
    end
  end

  for (genvar f = 1; f <= FLAG_LAT; f++) begin : g_flg
    always_ff @(posedge clk) begin
      if (en) flg_r[f] <= flg_r[f-1];
    end
  end

  // term chain inputs, lane 0 sine, lane 1 cosine
  logic [31:0]        x2_in   [N_TERMS];
  logic [31:0]        term_in [2][N_TERMS];
  logic signed [33:0] sum_in  [2][N_TERMS];
  logic [31:0]        x2_c_r  [N_TERMS];
  logic [31:0]        term_c_r [2][N_TERMS];
  logic signed [33:0] sum_c_r  [2][N_TERMS];

  assign x2_in[0] = sq_r[61:30];
  assign term_in[0][0] = 32'(xs_r);
  assign sum_in[0][0] = 34'(xs_r);
  assign term_in[1][0] = Q30_ONE;
  assign sum_in[1][0] = 34'(Q30_ONE);

  for (genvar t = 1; t < N_TERMS; t++) begin : g_link
    assign x2_in[t] = x2_c_r[t-1];
    assign term_in[0][t] = term_c_r[0][t-1];
    assign term_in[1][t] = term_c_r[1][t-1];
    assign sum_in[0][t] = sum_c_r[0][t-1];
    assign sum_in[1][t] = sum_c_r[1][t-1];
  end

  for (genvar t = 0; t < N_TERMS; t++) begin : g_term
    logic [31:0] x2_a_r, x2_b_r;

    always_ff @(posedge clk) begin
      if (en) begin
        x2_a_r <= x2_in[t];
        x2_b_r <= x2_a_r;
        x2_c_r[t] <= x2_b_r;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int DIV = (l == 0) ? (2 * t + 2) * (2 * t + 3)
                                    : (2 * t + 1) * (2 * t + 2);
      localparam logic [39:0] RECIP = 40'((41'd1 << 40) / DIV);

      logic [63:0]        p_a_r;
      logic signed [33:0] sum_a_r, sum_b_r;
      logic [31:0]        n_b_r;
      logic [71:0]        mp_b_r;
      logic [31:0]        n;
      logic [31:0]        q0;
      logic [41:0]        rem;
      logic [31:0]        q;

      assign n = p_a_r[61:30];
      assign q0 = mp_b_r[71:40];
      assign rem = 42'(n_b_r) - 42'(q0) * 42'(DIV);
      assign q = (rem >= 42'(DIV)) ? q0 + 32'd1 : q0;

      always_ff @(posedge clk) begin
        if (en) begin
          // product with x squared
          p_a_r <= 64'(term_in[l][t]) * 64'(x2_in[t]);
          sum_a_r <= sum_in[l][t];
          // reciprocal estimate of the constant divide
          n_b_r <= n;
          mp_b_r <= 72'(n) * 72'(RECIP);
          sum_b_r <= sum_a_r;
          // correct estimate, accumulate alternating sign
          term_c_r[l][t] <= q;
          sum_c_r[l][t] <= (t % 2 == 0) ? sum_b_r - 34'(q) : sum_b_r + 34'(q);
        end
      end
    end
  end

  // sign fix stage
  logic signed [33:0] s_fix, c_fix;
  logic [1:0]         flg;

  always_comb begin
    flg = flg_r[FLAG_LAT];
    s_fix = flg[0] ? -sum_c_r[0][N_TERMS-1] : sum_c_r[0][N_TERMS-1];
    c_fix = sum_c_r[1][N_TERMS-1];
    if (flg[1]) begin
      s_fix = -s_fix;
      c_fix = -c_fix;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= s_fix;
      cos_o <= c_fix;
    end
  end

endmodule
`default_nettype wire

/* sv/euler_xyz_to_pose_matrix.sv */
// top level: euler xyz pose to the upper three rows of a homogeneous transform
`default_nettype none
// Takes one pose request per cycle (translation q16.16, angles about x, y, z in
// signed radians with ANGLE_WIDTH-3 fraction bits) and returns the rotation
// R = Rx*Ry*Rz as q1.COEF_FRAC entries, rounded and saturated to +/-1, with the
// translation copied alongside. Throughput is one request per cycle while no
// finished result is stalled. Each request passes the series sine/cosine unit
// (fold, square, three stages for each of eight terms, sign fix), then four
// stages of matrix products. The whole pipeline freezes while a finished result
// is stalled, so in_stall follows out_stall whenever out_valid is high. Zero
// angles give an exact identity factor.
module euler_xyz_to_pose_matrix #(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_FRAC   = 14
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [31:0]            in_shift_x,
  input  wire logic signed [31:0]            in_shift_y,
  input  wire logic signed [31:0]            in_shift_z,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_angle_x,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_angle_y,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_angle_z,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COEF_FRAC+1:0]        out_m00,
  output logic signed [COEF_FRAC+1:0]        out_m01,
  output logic signed [COEF_FRAC+1:0]        out_m02,
  output logic signed [COEF_FRAC+1:0]        out_m10,
  output logic signed [COEF_FRAC+1:0]        out_m11,
  output logic signed [COEF_FRAC+1:0]        out_m12,
  output logic signed [COEF_FRAC+1:0]        out_m20,
  output logic signed [COEF_FRAC+1:0]        out_m21,
  output logic signed [COEF_FRAC+1:0]        out_m22,
  output logic signed [31:0]                 out_x,
  output logic signed [31:0]                 out_y,
  output logic signed [31:0]                 out_z
);
  import eul_pkg::*;

  localparam int TOT = SC_LAT + MAT_LAT;
  localparam int RSH = 60 - COEF_FRAC;

  // global advance: every stage moves unless a finished result is held
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits ride alongside the data
  logic [TOT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[TOT-1];

  // translation delay line matching the rotation path
  logic signed [31:0] tx_r [TOT];
  logic signed [31:0] ty_r [TOT];
  logic signed [31:0] tz_r [TOT];
  always_ff @(posedge clk) begin
    if (en) begin
      tx_r[0] <= in_shift_x;
      ty_r[0] <= in_shift_y;
      tz_r[0] <= in_shift_z;
    end
  end
  for (genvar d = 1; d < TOT; d++) begin : g_tdly
    always_ff @(posedge clk) begin
      if (en) begin
        tx_r[d] <= tx_r[d-1];
        ty_r[d] <= ty_r[d-1];
        tz_r[d] <= tz_r[d-1];
      end
    end
  end
  assign out_x = tx_r[TOT-1];
  assign out_y = ty_r[TOT-1];
  assign out_z = tz_r[TOT-1];

  // one sine/cosine pipe per axis
  logic signed [33:0] sx, cx, sy, cy, sz, cz;

  eul_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_x (
    .clk(clk), .en(en), .ang(in_angle_x), .sin_o(sx), .cos_o(cx)
  );
  eul_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_y (
    .clk(clk), .en(en), .ang(in_angle_y), .sin_o(sy), .cos_o(cy)
  );
  eul_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_z (
    .clk(clk), .en(en), .ang(in_angle_z), .sin_o(sz), .cos_o(cz)
  );

  // stage m1: the four cross products of Rx*Ry
  logic signed [67:0] p_sxsy_r, p_sxcy_r, p_cxsy_r, p_cxcy_r;
  logic signed [33:0] cx1_r, sx1_r, cy1_r, sy1_r, cz1_r, sz1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_sxsy_r <= 68'(sx) * 68'(sy);
      p_sxcy_r <= 68'(sx) * 68'(cy);
      p_cxsy_r <= 68'(cx) * 68'(sy);
      p_cxcy_r <= 68'(cx) * 68'(cy);
      cx1_r <= cx;
      sx1_r <= sx;
      cy1_r <= cy;
      sy1_r <= sy;
      cz1_r <= cz;
      sz1_r <= sz;
    end
  end

  // stage m2: round to q30, negate before rounding where the entry is negative
  function automatic logic signed [33:0] rnd30(input logic signed [67:0] p);
    logic signed [67:0] q;
    q = (p + (68'sd1 <<< 29)) >>> 30;
    return q[33:0];
  endfunction

  logic signed [33:0] a_r [3][3];
  logic signed [33:0] cz2_r, sz2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0][0] <= cy1_r;
      a_r[0][1] <= '0;
      a_r[0][2] <= sy1_r;
      a_r[1][0] <= rnd30(p_sxsy_r);
      a_r[1][1] <= cx1_r;
      a_r[1][2] <= rnd30(-p_sxcy_r);
      a_r[2][0] <= rnd30(-p_cxsy_r);
      a_r[2][1] <= sx1_r;
      a_r[2][2] <= rnd30(p_cxcy_r);
      cz2_r <= cz1_r;
      sz2_r <= sz1_r;
    end
  end

  // stages m3 and m4: multiply by Rz, round, saturate
  logic signed [COEF_FRAC+1:0] m_r [3][3];
  localparam logic signed [68:0] LIM = 69'sd1 <<< COEF_FRAC;

  for (genvar i = 0; i < 3; i++) begin : g_row
    logic signed [67:0] pa_r, pb_r, pc_r, pd_r;
    logic signed [33:0] a2_r;
    logic signed [68:0] s0, s1, s2;

    always_ff @(posedge clk) begin
      if (en) begin
        pa_r <= 68'(a_r[i][0]) * 68'(cz2_r);
        pb_r <= 68'(a_r[i][1]) * 68'(sz2_r);
        pc_r <= 68'(a_r[i][0]) * 68'(sz2_r);
        pd_r <= 68'(a_r[i][1]) * 68'(cz2_r);
        a2_r <= a_r[i][2];
      end
    end

    function automatic logic signed [COEF_FRAC+1:0] rsat(input logic signed [68:0] v);
      logic signed [68:0] q;
      q = (v + (69'sd1 <<< (RSH - 1))) >>> RSH;
      if (q > LIM) q = LIM;
      if (q < -LIM) q = -LIM;
      return q[COEF_FRAC+1:0];
    endfunction

    assign s0 = 69'(pa_r) + 69'(pb_r);
    assign s1 = 69'(pd_r) - 69'(pc_r);
    assign s2 = 69'(a2_r) <<< 30;

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i][0] <= rsat(s0);
        m_r[i][1] <= rsat(s1);
        m_r[i][2] <= rsat(s2);
      end
    end
  end

  assign out_m00 = m_r[0][0];
  assign out_m01 = m_r[0][1];
  assign out_m02 = m_r[0][2];
  assign out_m10 = m_r[1][0];
  assign out_m11 = m_r[1][1];
  assign out_m12 = m_r[1][2];
  assign out_m20 = m_r[2][0];
  assign out_m21 = m_r[2][1];
  assign out_m22 = m_r[2][2];

endmodule
`default_nettype wire

/* test/tb_euler_xyz_to_pose_matrix.sv */
// self-checking testbench for the euler xyz pose to transform matrix pipeline
`timescale 1ns / 100ps
module tb_euler_xyz_to_pose_matrix;
  import eul_pkg::*;

  // one pose request as driven onto the input ports
  typedef struct {
    logic signed [31:0] sx, sy, sz;
    logic signed [15:0] ax, ay, az;
    bit                 drain;  // hold this request until the pipe is empty
  } pose_t;

  // one transform as the output ports carry it
  typedef struct {
    longint m [9];
    longint tx, ty, tz;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_shift_x = '0, in_shift_y = '0, in_shift_z = '0;
  logic signed [15:0] in_angle_x = '0, in_angle_y = '0, in_angle_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [15:0] out_m20, out_m21, out_m22;
  logic signed [31:0] out_x, out_y, out_z;

  pose_t  pending_poses [$];
  xform_t expected_xforms [$];
  bit     failed = 1'b0;

  // handshake flags seen at the last rising edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  // idle control for each side
  int  send_gap = 0;
  int  stall_left = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  euler_xyz_to_pose_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_shift_x(in_shift_x), .in_shift_y(in_shift_y), .in_shift_z(in_shift_z),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  always #6 clk = ~clk;

  // taylor series sine and cosine in q30, folded by a half turn beyond pi/2
  function automatic void series_sin_cos(input logic signed [15:0] ang,
                                         output longint s, output longint c);
    longint z;
    bit flip;
    bit neg;
    longint unsigned x, x2, term;
    longint ss, cc;
    bit sub;
    z = longint'(ang) * 64'sd131072;
    flip = 1'b0;
    if (z > longint'(Q30_HPI)) begin
      z = z - longint'(Q30_PI);
      flip = 1'b1;
    end else if (z < -longint'(Q30_HPI)) begin
      z = z + longint'(Q30_PI);
      flip = 1'b1;
    end
    neg = z < 0;
    x = neg ? longint'(-z) : z;
    x2 = (x * x) >> 30;
    // sine: odd powers
    term = x;
    ss = x;
    sub = 1'b1;
    for (int k = 2; k <= 16; k += 2) begin
      term = ((term * x2) >> 30) / longint'(k * (k + 1));
      ss = sub ? ss - longint'(term) : ss + longint'(term);
      sub = !sub;
    end
    // cosine: even powers
    term = 64'd1 << 30;
    cc = 64'sd1 <<< 30;
    sub = 1'b1;
    for (int k = 1; k <= 15; k += 2) begin
      term = ((term * x2) >> 30) / longint'(k * (k + 1));
      cc = sub ? cc - longint'(term) : cc + longint'(term);
      sub = !sub;
    end
    if (neg) ss = -ss;
    if (flip) begin
      ss = -ss;
      cc = -cc;
    end
    s = ss;
    c = cc;
  endfunction

  // rotation rx*ry*rz rounded to q1.14 and saturated, translation copied
  function automatic xform_t pose_to_xform(input pose_t p);
    xform_t r;
    longint sx, cx, sy, cy, sz, cz;
    longint rx [3][3], ry [3][3], rz [3][3], a [3][3];
    longint acc, v;
    longint one;
    one = 64'sd1 <<< 30;
    series_sin_cos(p.ax, sx, cx);
    series_sin_cos(p.ay, sy, cy);
    series_sin_cos(p.az, sz, cz);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        rx[i][j] = 0;
        ry[i][j] = 0;
        rz[i][j] = 0;
      end
    rx[0][0] = one; rx[1][1] = cx; rx[1][2] = -sx; rx[2][1] = sx; rx[2][2] = cx;
    ry[1][1] = one; ry[0][0] = cy; ry[0][2] = sy; ry[2][0] = -sy; ry[2][2] = cy;
    rz[2][2] = one; rz[0][0] = cz; rz[0][1] = -sz; rz[1][0] = sz; rz[1][1] = cz;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rx[i][k] * ry[k][j];
        a[i][j] = (acc + (64'sd1 <<< 29)) >>> 30;
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * rz[k][j];
        v = (acc + (64'sd1 <<< 45)) >>> 46;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        r.m[i * 3 + j] = v;
      end
    r.tx = longint'(p.sx);
    r.ty = longint'(p.sy);
    r.tz = longint'(p.sz);
    return r;
  endfunction

  task automatic queue_pose(input longint sx, sy, sz, input int ax, ay, az,
                            input bit drain = 1'b0);
    pose_t p;
    p.sx = 32'(sx); p.sy = 32'(sy); p.sz = 32'(sz);
    p.ax = 16'(ax); p.ay = 16'(ay); p.az = 16'(az);
    p.drain = drain;
    pending_poses.push_back(p);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // request driver: payload and valid change at the falling edge
  always @(negedge clk) begin
    pose_t p;
    if (rst_n && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_poses.size() != 0 &&
                   !(pending_poses[0].drain && expected_xforms.size() != 0)) begin
        p = pending_poses.pop_front();
        in_shift_x <= p.sx; in_shift_y <= p.sy; in_shift_z <= p.sz;
        in_angle_x <= p.ax; in_angle_y <= p.ay; in_angle_z <= p.az;
        in_valid <= 1'b1;
        // bursts with no idling now and then
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap <= send_burst ? 0 : $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall, drawn once per accepted result
  always @(negedge clk) begin
    int n;
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        n = recv_burst ? 0 : $urandom_range(0, 19);
      end else begin
        n = stall_left;
      end
      out_stall <= n > 0;
      stall_left <= n > 0 ? n - 1 : 0;
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    xform_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) begin
      pose_t p;
      p.sx = in_shift_x; p.sy = in_shift_y; p.sz = in_shift_z;
      p.ax = in_angle_x; p.ay = in_angle_y; p.az = in_angle_z;
      p.drain = 1'b0;
      expected_xforms.push_back(pose_to_xform(p));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_xforms.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual m00=%0d x=%0d",
                 $time, out_m00, out_x);
        failed = 1'b1;
      end else begin
        want = expected_xforms.pop_front();
        check_field("m00", want.m[0], out_m00);
        check_field("m01", want.m[1], out_m01);
        check_field("m02", want.m[2], out_m02);
        check_field("m10", want.m[3], out_m10);
        check_field("m11", want.m[4], out_m11);
        check_field("m12", want.m[5], out_m12);
        check_field("m20", want.m[6], out_m20);
        check_field("m21", want.m[7], out_m21);
        check_field("m22", want.m[8], out_m22);
        check_field("out_x", want.tx, out_x);
        check_field("out_y", want.ty, out_y);
        check_field("out_z", want.tz, out_z);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int ax, ay, az;
    // zero pose is the exact identity
    queue_pose(0, 0, 0, 0, 0, 0);
    // translation extremes pass straight through
    queue_pose(32'h7fffffff, -32'sh80000000, -1, 0, 0, 0);
    queue_pose(-32'sh80000000, 32'h7fffffff, 1, 0, 0, 0);
    // angle field extremes on each axis
    queue_pose(1, 2, 3, 32767, 0, 0);
    queue_pose(1, 2, 3, -32768, 0, 0);
    queue_pose(1, 2, 3, 0, 32767, 0);
    queue_pose(1, 2, 3, 0, -32768, 0);
    queue_pose(1, 2, 3, 0, 0, 32767);
    queue_pose(1, 2, 3, 0, 0, -32768);
    queue_pose(5, 6, 7, 32767, 32767, 32767);
    queue_pose(5, 6, 7, -32768, -32768, -32768);
    // either side of the half-turn fold at plus and minus pi/2
    queue_pose(0, 0, 0, 12867, 0, 0);
    queue_pose(0, 0, 0, 12868, 0, 0);
    queue_pose(0, 0, 0, -12867, 0, 0);
    queue_pose(0, 0, 0, -12868, 0, 0);
    queue_pose(0, 0, 0, 12867, 12868, -12868);
    // near pi, and eighth and quarter turns that push entries toward saturation
    queue_pose(0, 0, 0, 25736, 0, -25736);
    queue_pose(0, 0, 0, 6434, 6434, 6434);
    queue_pose(0, 0, 0, -6434, 12868, 25736);
    queue_pose(0, 0, 0, 1, -1, 1);

    for (int i = 0; i < 500; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          // small angles, no fold
          ax = $urandom_range(0, 25734) - 12867;
          ay = $urandom_range(0, 25734) - 12867;
          az = $urandom_range(0, 25734) - 12867;
        end
        1: begin
          // one axis only
          ax = 0; ay = 0; az = 0;
          case ($urandom_range(0, 2))
            0: ax = $signed(16'($urandom));
            1: ay = $signed(16'($urandom));
            default: az = $signed(16'($urandom));
          endcase
        end
        default: begin
          ax = $signed(16'($urandom));
          ay = $signed(16'($urandom));
          az = $signed(16'($urandom));
        end
      endcase
      // every so often hold off until the pipe has drained
      queue_pose($signed(32'($urandom)), $signed(32'($urandom)), $signed(32'($urandom)),
                 ax, ay, az, i == 100 || i == 350);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_poses.size() == 0 && !in_valid && expected_xforms.size() == 0);
    // pipeline is 31 deep; allow for trailing stray results
    repeat (60) @(posedge clk);
    if (!failed)
      $display("euler_xyz_to_pose_matrix regression: pass");
    else
      $display("euler_xyz_to_pose_matrix regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("euler_xyz_to_pose_matrix regression: fail");
    $finish;
  end

endmodule
